@@ src/sfq_pkg.sv @@
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants of the shortest-first request queue: built
// depth, field widths, request and response structs, cell control struct.
// ----------------------------------------------------------------------------
package sfq_pkg;

    localparam int DEPTH     = 16;
    localparam int SIZE_BITS = 32;
    localparam int TAG_BITS  = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic REG_SCHED_MODE = 1'b0;
    localparam logic REG_CAPACITY   = 1'b1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);

    typedef struct packed {
        logic                 op;
        logic [SIZE_BITS-1:0] file_size;
        logic [TAG_BITS-1:0]  request_tag;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [SIZE_BITS-1:0] out_file_size;
        logic [TAG_BITS-1:0]  out_tag;
        logic [CNT_W-1:0]     occupancy;
    } rsp_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic   put;
        logic   get;
        logic   sort;
        entry_t item;
    } cell_ctl_t;

endpackage

@@ src/sfq_cell.sv @@
// ----------------------------------------------------------------------------
// sfq_cell
// One queue slot. Holds one entry, compares it with the incoming request,
// and takes its next value from itself, a neighbor or the new request.
// ----------------------------------------------------------------------------
module sfq_cell
    import sfq_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  logic      at_tail,
    input  logic      left_shift,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    input  logic      tail_in,
    output entry_t    entry,
    output logic      shift,
    output logic      tail_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   larger;

    assign larger   = entry_reg.size > ctl.item.size;
    assign tail_out = !occupied || (larger && tail_in);
    assign shift    = ctl.put && ctl.sort && occupied && larger && tail_in;
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.get) begin
            entry_next = right_entry;
        end else if (ctl.put) begin
            if (left_shift) begin
                entry_next = left_entry;
            end else if (shift || at_tail) begin
                entry_next = ctl.item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/shortest_first_request_queue.sv @@
// ----------------------------------------------------------------------------
// shortest_first_request_queue
// Bounded request queue with first-come or smallest-size-first ordering,
// built as a row of slot cells.
// ----------------------------------------------------------------------------
// Takes one request per cycle while s_ready is high; its response is registered
// and appears the cycle after acceptance. All slots update together: on a get
// every slot takes its right neighbor, on a sorted put the slots holding a
// trailing run of larger sizes move one place back and the new request drops
// into the gap. That trailing-run test ripples through the whole row of DEPTH
// cells and sets the cycle time. A put to a full queue and a get from an
// empty queue answer ok=0 with zero data. Write configuration only while idle.
module shortest_first_request_queue
    import sfq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic             mode_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    rsp_t             m_data_reg;
    rsp_t             m_data_next;
    logic             accept;
    logic             put_ok;
    logic             get_ok;
    logic [CNT_W-1:0] limit;
    cell_ctl_t        ctl;
    logic             cfg_wr;

    entry_t           entry  [DEPTH];
    logic             shift  [DEPTH];
    logic             tail   [DEPTH+1];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_reg) : DATA_W'(mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            cap_reg  <= CAPACITY_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SCHED_MODE: mode_reg <= pwdata[0];
                REG_CAPACITY:   cap_reg  <= pwdata[CAP_W-1:0];
                default:        mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            limit = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > CNT_W'(DEPTH)) begin
            limit = CNT_W'(DEPTH);
        end else begin
            limit = CNT_W'(cap_reg);
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign put_ok  = accept && (s_data.op == OP_PUT) && (count_reg < limit);
    assign get_ok  = accept && (s_data.op == OP_GET) && (count_reg != '0);

    assign ctl.put       = put_ok;
    assign ctl.get       = get_ok;
    assign ctl.sort      = mode_reg;
    assign ctl.item.size = s_data.file_size;
    assign ctl.item.tag  = s_data.request_tag;

    assign tail[DEPTH] = 1'b1;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sfq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (CNT_W'(i) < count_reg),
            .at_tail     (CNT_W'(i) == count_reg),
            .left_shift  ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i-1]),
            .left_entry  ((i == 0) ? ctl.item : entry[(i == 0) ? 0 : i-1]),
            .right_entry ((i == DEPTH-1) ? entry[i] : entry[(i == DEPTH-1) ? i : i+1]),
            .tail_in     (tail[i+1]),
            .entry       (entry[i]),
            .shift       (shift[i]),
            .tail_out    (tail[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (put_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (get_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
        m_data_next.ok            = put_ok || get_ok;
        m_data_next.out_file_size = get_ok ? entry[0].size : '0;
        m_data_next.out_tag       = get_ok ? entry[0].tag : '0;
        m_data_next.occupancy     = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.occupancy == count_reg))
        else $error("response occupancy differs from held count");

    a_empty_get: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.op == OP_GET) && (count_reg == '0)) |=>
            (!m_data_reg.ok && (m_data_reg.out_tag == '0)))
        else $error("get from empty queue reported data");

    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        put_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("stored put did not advance count");
`endif

endmodule
